FILE: src/jls_pkg.sv
package jls_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int VALUE_BITS = 32;

  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 13;
  localparam int CHG_BITS      = VALUE_BITS - 1;
  localparam int SUM_BITS      = VALUE_BITS + 2;
  localparam int DIFF_BITS     = VALUE_BITS + 1;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WIDTH_BITS-1:0]  MIN_W      = WIDTH_BITS'(3);
  localparam logic [WIDTH_BITS-1:0]  MAX_W      = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] MIN_H      = HEIGHT_BITS'(3);
  localparam logic [HEIGHT_BITS-1:0] MAX_H      = HEIGHT_BITS'(MAX_HEIGHT);
  localparam logic [WIDTH_BITS-1:0]  RESET_W    = WIDTH_BITS'(1024);
  localparam logic [HEIGHT_BITS-1:0] RESET_H    = HEIGHT_BITS'(1024);
  localparam logic [CHG_BITS-1:0]    CHG_MAX    = {CHG_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [COL_BITS-1:0]          col_t;
  typedef logic [ROW_BITS-1:0]          row_t;
  typedef logic [CHG_BITS-1:0]          chg_t;

  typedef struct packed {
    value_t sample;
    logic   clr_max;
    col_t   col;
    row_t   row_out;
    logic   emit;
    logic   last;
  } jls_item_t;

endpackage

FILE: src/jls_in_if.sv
interface jls_in_if;
  import jls_pkg::*;

  logic   valid;
  logic   ready;
  value_t sample_value;
  logic   frame_start;

  modport source (output valid, sample_value, frame_start, input ready);
  modport sink   (input valid, sample_value, frame_start, output ready);
endinterface

FILE: src/jls_out_if.sv
interface jls_out_if;
  import jls_pkg::*;

  logic   valid;
  logic   ready;
  value_t new_value;
  row_t   out_row;
  col_t   out_col;
  chg_t   max_change;
  logic   last_of_frame;

  modport source (output valid, new_value, out_row, out_col, max_change, last_of_frame,
                  input ready);
  modport sink   (input valid, new_value, out_row, out_col, max_change, last_of_frame,
                  output ready);
endinterface

FILE: src/jls_cfg_if.sv
interface jls_cfg_if;
  import jls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/jls_ram.sv
module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/jls_front.sv
module jls_front (
  input  logic                           clk,
  input  logic                           rst,
  jls_in_if.sink                         samples,
  input  logic [jls_pkg::WIDTH_BITS-1:0]  grid_width,
  input  logic [jls_pkg::HEIGHT_BITS-1:0] grid_height,
  input  logic                           q_full,
  output logic                           push,
  output jls_pkg::jls_item_t             item
);
  import jls_pkg::*;

  col_t                   col_cnt;
  row_t                   row_cnt;
  col_t                   col_cnt_next;
  row_t                   row_cnt_next;
  logic [WIDTH_BITS-1:0]  w;
  logic [HEIGHT_BITS-1:0] h;
  col_t                   c_raw;
  row_t                   r_raw;
  col_t                   c;
  row_t                   r;
  logic [WIDTH_BITS-1:0]  c_ext;
  logic [HEIGHT_BITS-1:0] r_ext;

  assign samples.ready = !q_full;
  assign push          = samples.valid && !q_full;

  always_comb begin
    if (grid_width < MIN_W) begin
      w = MIN_W;
    end else if (grid_width > MAX_W) begin
      w = MAX_W;
    end else begin
      w = grid_width;
    end
    if (grid_height < MIN_H) begin
      h = MIN_H;
    end else if (grid_height > MAX_H) begin
      h = MAX_H;
    end else begin
      h = grid_height;
    end

    c_raw = samples.frame_start ? '0 : col_cnt;
    r_raw = samples.frame_start ? '0 : row_cnt;
    c = ({1'b0, c_raw} >= w) ? COL_BITS'(w - WIDTH_BITS'(1)) : c_raw;
    r = ({1'b0, r_raw} >= h) ? ROW_BITS'(h - HEIGHT_BITS'(1)) : r_raw;
    c_ext = {1'b0, c};
    r_ext = {1'b0, r};

    item.sample  = samples.sample_value;
    item.clr_max = samples.frame_start;
    item.col     = c;
    item.row_out = r - ROW_BITS'(1);
    item.emit    = (r >= ROW_BITS'(2)) && (c != '0) && (c_ext + WIDTH_BITS'(2) <= w);
    item.last    = (r_ext - HEIGHT_BITS'(1) == h - HEIGHT_BITS'(2))
                   && (c_ext == w - WIDTH_BITS'(2));

    // wrap at the end of a row and at the end of the grid
    if (c_ext + WIDTH_BITS'(1) >= w) begin
      col_cnt_next = '0;
      row_cnt_next = (r_ext + HEIGHT_BITS'(1) >= h) ? '0 : r + ROW_BITS'(1);
    end else begin
      col_cnt_next = c + COL_BITS'(1);
      row_cnt_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (push) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  a_emit_interior: assert property (@(posedge clk) disable iff (rst)
    push && item.emit |-> item.col != '0 && item.row_out != '0)
    else $error("interior result classified on a boundary cell");

endmodule

FILE: src/jls_queue.sv
module jls_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jls_pkg::jls_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output jls_pkg::jls_item_t head
);
  import jls_pkg::*;

  jls_item_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full     = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_BITS'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

FILE: src/jls_back.sv
module jls_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  jls_pkg::jls_item_t q_head,
  output logic               pop,
  jls_out_if.source          results
);
  import jls_pkg::*;

  logic      s1_valid;
  jls_item_t s1_item;
  logic      s1_fwd_a;
  logic      s1_fwd_b;
  value_t    s1_fwd_sample;
  value_t    s1_fwd_center;
  value_t    left_tap;
  chg_t      run_max;
  chg_t      run_max_next;

  logic      o_valid;
  value_t    o_value;
  row_t      o_row;
  col_t      o_col;
  chg_t      o_max;
  logic      o_last;

  logic      out_free;
  logic      fire1;
  logic      adv0;
  col_t      right_addr;

  logic [VALUE_BITS-1:0] rd_center;
  logic [VALUE_BITS-1:0] rd_right;
  logic [VALUE_BITS-1:0] rd_up;

  value_t                     center;
  value_t                     right;
  value_t                     up;
  logic signed [SUM_BITS-1:0]  sum;
  value_t                     nv;
  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]        mag;
  chg_t                       chg;
  chg_t                       base;

  assign out_free   = !o_valid || results.ready;
  assign fire1      = s1_valid && out_free;
  assign adv0       = q_valid && (!s1_valid || fire1);
  assign pop        = adv0;
  assign right_addr = q_head.col + COL_BITS'(1);

  jls_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_above_c (
    .clk   (clk),
    .we    (fire1),
    .waddr (s1_item.col),
    .wdata (s1_item.sample),
    .re    (adv0),
    .raddr (q_head.col),
    .rdata (rd_center)
  );

  jls_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_above_r (
    .clk   (clk),
    .we    (fire1),
    .waddr (s1_item.col),
    .wdata (s1_item.sample),
    .re    (adv0),
    .raddr (right_addr),
    .rdata (rd_right)
  );

  jls_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_above2 (
    .clk   (clk),
    .we    (fire1),
    .waddr (s1_item.col),
    .wdata (center),
    .re    (adv0),
    .raddr (q_head.col),
    .rdata (rd_up)
  );

  // stencil and change tracking
  always_comb begin
    center = s1_fwd_a ? s1_fwd_sample : value_t'(rd_center);
    right  = s1_fwd_b ? s1_fwd_sample : value_t'(rd_right);
    up     = s1_fwd_a ? s1_fwd_center : value_t'(rd_up);
    sum    = SUM_BITS'(up) + SUM_BITS'(s1_item.sample) + SUM_BITS'(left_tap)
             + SUM_BITS'(right);
    nv     = sum[SUM_BITS-1:2];
    diff   = DIFF_BITS'(nv) - DIFF_BITS'(center);
    mag    = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    chg    = (|mag[DIFF_BITS-1:DIFF_BITS-2]) ? CHG_MAX : mag[CHG_BITS-1:0];
    base   = s1_item.clr_max ? '0 : run_max;
    run_max_next = (s1_item.emit && chg > base) ? chg : base;
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      s1_item       <= q_head;
      // bypass the line-buffer write that lands in the same cycle as the read
      s1_fwd_a      <= fire1 && (q_head.col == s1_item.col);
      s1_fwd_b      <= fire1 && (right_addr == s1_item.col);
      s1_fwd_sample <= s1_item.sample;
      s1_fwd_center <= center;
    end
    if (fire1 && s1_item.emit) begin
      o_value <= nv;
      o_row   <= s1_item.row_out;
      o_col   <= s1_item.col;
      o_max   <= run_max_next;
      o_last  <= s1_item.last;
    end
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
      left_tap <= '0;
      run_max  <= '0;
    end else begin
      if (adv0) begin
        s1_valid <= 1'b1;
      end else if (fire1) begin
        s1_valid <= 1'b0;
      end
      if (fire1) begin
        o_valid  <= s1_item.emit;
        left_tap <= center;
        run_max  <= run_max_next;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign results.valid         = o_valid;
  assign results.new_value     = o_value;
  assign results.out_row       = o_row;
  assign results.out_col       = o_col;
  assign results.max_change    = o_max;
  assign results.last_of_frame = o_last;

  a_max_monotonic: assert property (@(posedge clk) disable iff (rst)
    fire1 && !s1_item.clr_max |=> run_max >= $past(run_max))
    else $error("running max change decreased within a sweep");

  a_fwd_exclusive: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1_fwd_a && s1_fwd_b))
    else $error("center and right bypass selected together");

  a_last_interior: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_last |-> o_col != '0 && o_row != '0)
    else $error("end of sweep flagged on a boundary cell");

endmodule

FILE: src/jacobi_laplace_stencil_sweep.sv
// path: input -> queue slot -> s1 stage register -> output register
// throughput: one grid cell per cycle while results.ready is high, set by the back
//   stage's four-neighbor add and change compare, one read port per line-buffer copy
// reset: clears row/column counters, running max change, left tap, queue and
//   output valid; grid_width and grid_height return to 1024; line buffers keep contents
module jacobi_laplace_stencil_sweep (
  input  logic      clk,
  input  logic      rst,
  jls_cfg_if.sink   cfg,
  jls_in_if.sink    samples,
  jls_out_if.source results
);
  import jls_pkg::*;

  logic [WIDTH_BITS-1:0]  grid_width;
  logic [HEIGHT_BITS-1:0] grid_height;

  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      pop;
  jls_item_t front_item;
  jls_item_t q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RESET_W;
      grid_height <= RESET_H;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GRID_WIDTH:  grid_width  <= cfg.data[WIDTH_BITS-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg.data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  jls_front u_front (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .q_full      (q_full),
    .push        (push),
    .item        (front_item)
  );

  jls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_valid),
    .head      (q_head)
  );

  jls_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .results (results)
  );

endmodule

FILE: sim/jls_sweep_checker.sv
`timescale 1ns / 1ps

module jls_sweep_checker (
  input  logic clk,
  input  logic rst,
  jls_cfg_if   cfg_mon,
  jls_in_if    cell_mon,
  jls_out_if   res_mon,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  import jls_pkg::*;

  typedef struct packed {
    value_t value;
    row_t   row;
    col_t   col;
    chg_t   max_chg;
    logic   last;
  } point_t;

  logic [WIDTH_BITS-1:0]  width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;
  value_t                 above_row [MAX_WIDTH];
  value_t                 above2_row [MAX_WIDTH];
  value_t                 left_tap;
  int unsigned            col_pos;
  int unsigned            row_pos;
  chg_t                   peak_change;
  point_t                 expected_points [$];
  point_t                 want_pt;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void stencil_step(value_t sample, logic new_frame);
    int unsigned w, h, c, r;
    value_t      center, right, up;
    longint      sum, nv, delta;
    point_t      pt;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (new_frame) begin
      col_pos     = 0;
      row_pos     = 0;
      peak_change = '0;
    end
    // counters left past the edge by a mid-sweep resize sit on the last column or row
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    center = above_row[c];
    right  = (c + 1 < MAX_WIDTH) ? above_row[c + 1] : '0;
    up     = above2_row[c];
    if (r >= 2 && c >= 1 && c + 2 <= w) begin
      sum   = longint'(up) + longint'(sample) + longint'(left_tap) + longint'(right);
      nv    = sum >>> 2;
      delta = nv - longint'(center);
      if (delta < 0) delta = -delta;
      if (delta > longint'(CHG_MAX)) delta = longint'(CHG_MAX);
      if (delta > longint'(peak_change)) peak_change = chg_t'(delta);
      pt.value   = value_t'(nv);
      pt.row     = row_t'(r - 1);
      pt.col     = col_t'(c);
      pt.max_chg = peak_change;
      pt.last    = (r - 1 == h - 2) && (c == w - 2);
      expected_points.push_back(pt);
    end
    left_tap      = center;
    above2_row[c] = center;
    above_row[c]  = sample;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch at row %0d col %0d, expected %h, actual %h",
               $time, name, want_pt.row, want_pt.col, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg   = RESET_W;
      height_reg  = RESET_H;
      col_pos     = 0;
      row_pos     = 0;
      peak_change = '0;
      left_tap    = '0;
      expected_points.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_GRID_WIDTH:  width_reg = cfg_mon.data[WIDTH_BITS-1:0];
          REG_GRID_HEIGHT: height_reg = cfg_mon.data[HEIGHT_BITS-1:0];
          default: ;
        endcase
      end
      if (cell_mon.valid && cell_mon.ready)
        stencil_step(cell_mon.sample_value, cell_mon.frame_start);
      if (res_mon.valid && res_mon.ready) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, expected nothing, actual row %0d col %0d %h",
                   $time, res_mon.out_row, res_mon.out_col, res_mon.new_value);
        end else begin
          want_pt = expected_points.pop_front();
          checked++;
          check_field("new_value", want_pt.value, res_mon.new_value);
          check_field("out_row", want_pt.row, res_mon.out_row);
          check_field("out_col", want_pt.col, res_mon.out_col);
          check_field("max_change", want_pt.max_chg, res_mon.max_change);
          check_field("last_of_frame", want_pt.last, res_mon.last_of_frame);
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

FILE: sim/tb_jacobi_laplace_stencil_sweep.sv
`timescale 1ns / 1ps

module tb_jacobi_laplace_stencil_sweep;
  import jls_pkg::*;

  typedef enum int {
    MIX_WIDE,
    MIX_SMALL,
    MIX_EDGE,
    MIX_ANY
  } value_mix_e;

  localparam value_t VALUE_TOP    = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VALUE_BOTTOM = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic clk    = 1'b0;
  logic rst    = 1'b1;
  logic steady = 1'b0;
  int   fail_count;
  int   pending;
  int   checked;
  int   grid_w;
  int   grid_h;
  int   cells_sent;
  int   size_writes;

  jls_cfg_if cfg_bus ();
  jls_in_if  cell_bus ();
  jls_out_if res_bus ();

  jacobi_laplace_stencil_sweep u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .samples (cell_bus),
    .results (res_bus)
  );

  jls_sweep_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_mon    (cfg_bus),
    .cell_mon   (cell_bus),
    .res_mon    (res_bus),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    res_bus.ready <= steady || ($urandom_range(99) >= 29);
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic value_t pick_value(value_mix_e mix);
    value_mix_e sel;
    sel = (mix == MIX_ANY) ? value_mix_e'($urandom_range(0, 2)) : mix;
    case (sel)
      MIX_WIDE:  return value_t'($urandom);
      MIX_SMALL: return value_t'($urandom_range(0, 'h3FFFF)) - value_t'('h20000);
      default: begin
        case ($urandom_range(0, 4))
          0:       return VALUE_TOP;
          1:       return VALUE_BOTTOM;
          2:       return '0;
          3:       return '1;
          default: return value_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_cell(input value_t v, input logic fresh);
    while (!steady && $urandom_range(99) < 29) begin
      cell_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cell_bus.valid        <= 1'b1;
    cell_bus.sample_value <= v;
    cell_bus.frame_start  <= fresh;
    @(posedge clk);
    while (!cell_bus.ready) @(posedge clk);
    cells_sent++;
  endtask

  task automatic send_cells(input int count, input logic fresh, input value_mix_e mix);
    for (int i = 0; i < count; i++) send_cell(pick_value(mix), fresh && i == 0);
  endtask

  // stop the stream and let the pipeline empty
  task automatic settle();
    cell_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
    size_writes++;
  endtask

  task automatic resize(input int w, input int h);
    logic [CFG_DATA_BITS-1:0] w_code;
    logic [CFG_DATA_BITS-1:0] h_code;
    w_code = CFG_DATA_BITS'(w);
    h_code = CFG_DATA_BITS'(h);
    // out-of-range codes that land on the same size
    if (w == 3 && $urandom_range(0, 2) == 0)
      w_code = CFG_DATA_BITS'($urandom_range(0, 2));
    if (w == MAX_WIDTH && $urandom_range(0, 1) == 0)
      w_code = CFG_DATA_BITS'($urandom_range(MAX_WIDTH + 1, 2047));
    if ($urandom_range(0, 3) == 0)
      w_code[CFG_DATA_BITS-1:WIDTH_BITS] = (CFG_DATA_BITS-WIDTH_BITS)'($urandom_range(1, 3));
    if (h == 3 && $urandom_range(0, 2) == 0)
      h_code = CFG_DATA_BITS'($urandom_range(0, 2));
    if (h == MAX_HEIGHT && $urandom_range(0, 1) == 0)
      h_code = CFG_DATA_BITS'($urandom_range(MAX_HEIGHT + 1, 8191));
    grid_w = w;
    grid_h = h;
    write_reg(REG_GRID_WIDTH, w_code);
    write_reg(REG_GRID_HEIGHT, h_code);
  endtask

  initial begin
    int         phase;
    int         variant;
    int         small_cells;
    int         start;
    value_mix_e mix;
    phase       = 0;
    small_cells = 0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= REG_GRID_WIDTH;
    cfg_bus.data          <= '0;
    cell_bus.valid        <= 1'b0;
    cell_bus.sample_value <= '0;
    cell_bus.frame_start  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // smallest grid, sizes written below the legal range
    write_reg(REG_GRID_WIDTH, '0);
    write_reg(REG_GRID_HEIGHT, CFG_DATA_BITS'(2));
    grid_w = 3;
    grid_h = 3;

    // full-scale checkerboard: sum at the floor, change saturates, last flagged
    for (int i = 0; i < 9; i++)
      send_cell((i % 2 == 0) ? VALUE_TOP : VALUE_BOTTOM, i == 0);

    // negative sum rounds down, then the stream runs past the grid and wraps
    for (int i = 0; i < 17; i++)
      send_cell((i == 1) ? '1 : ((i < 9) ? value_t'('0) : pick_value(MIX_SMALL)), i == 0);

    while (small_cells < 650) begin
      phase++;
      steady <= (phase >= 10 && phase < 22);
      if ($urandom_range(0, 1) == 1) begin
        settle();
        resize($urandom_range(3, 12), $urandom_range(3, 8));
      end
      start   = cells_sent;
      variant = $urandom_range(0, 9);
      mix     = value_mix_e'($urandom_range(0, 3));
      case (variant)
        6: send_cells($urandom_range(1, grid_w * grid_h - 1), 1'b1, mix);
        7: send_cells(grid_w * grid_h + $urandom_range(1, 2 * grid_w * grid_h), 1'b1, mix);
        8: begin
          // shrink while partway through a sweep
          send_cells($urandom_range(grid_w + 1, grid_w * grid_h - 1), 1'b1, mix);
          settle();
          resize($urandom_range(3, grid_w), $urandom_range(3, grid_h));
          send_cells(grid_w * grid_h + $urandom_range(0, grid_w), 1'b0, mix);
        end
        default: send_cells(grid_w * grid_h, 1'b1, mix);
      endcase
      small_cells += cells_sent - start;
    end

    // a wide grid, then a tall one
    settle();
    steady <= 1'b1;
    resize(96, 4);
    send_cells(grid_w * grid_h, 1'b1, MIX_ANY);
    settle();
    steady <= 1'b0;
    resize(3, 64);
    send_cells(grid_w * grid_h, 1'b1, MIX_ANY);

    settle();
    $display("streamed %0d grid cells over %0d sweeps with %0d size register writes",
             cells_sent, phase + 4, size_writes);
    $display("compared %0d updated points, grids from 3x3 up to 96 wide and 64 tall",
             checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
